// File: rtl/mlo_pkg.sv
`default_nettype none
package mlo_pkg;

   localparam int ANG_W        = 17;
   localparam int Z_W          = ANG_W + 8;
   localparam int VEC_W        = 32;
   localparam int STEP_W       = 4;
   localparam int CORDIC_STEPS = 16;

   localparam logic signed [ANG_W-1:0] YAW_HALF    = 17'sd46080;
   localparam logic signed [ANG_W-1:0] QUARTER_ANG = 17'sd23040;
   localparam logic signed [VEC_W-1:0] CORDIC_X0   = 32'sd652032875;

   localparam logic [0:0] REG_SENSITIVITY = 1'b0;
   localparam logic [0:0] REG_PITCH_LIMIT = 1'b1;

   typedef struct packed {
      logic                    done;
      logic signed [VEC_W-1:0] cos_q;
      logic signed [VEC_W-1:0] sin_q;
   } cordic_res_type;

   // arctangent of 2^-i in 1/65536 degree
   function automatic logic signed [Z_W-1:0] atan_val(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         4'd0:  v = 25'sd2949120;
         4'd1:  v = 25'sd1740967;
         4'd2:  v = 25'sd919879;
         4'd3:  v = 25'sd466945;
         4'd4:  v = 25'sd234379;
         4'd5:  v = 25'sd117304;
         4'd6:  v = 25'sd58666;
         4'd7:  v = 25'sd29335;
         4'd8:  v = 25'sd14668;
         4'd9:  v = 25'sd7334;
         4'd10: v = 25'sd3667;
         4'd11: v = 25'sd1833;
         4'd12: v = 25'sd917;
         4'd13: v = 25'sd458;
         4'd14: v = 25'sd229;
         4'd15: v = 25'sd115;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/mlo_cordic.sv
`default_nettype none
module mlo_cordic (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [mlo_pkg::ANG_W-1:0]    angle,
   output mlo_pkg::cordic_res_type                  res
);

   logic signed [mlo_pkg::VEC_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [mlo_pkg::Z_W-1:0]    z_ff, z_in;
   logic [mlo_pkg::STEP_W-1:0]        cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              neg_ff, neg_in;

   logic signed [mlo_pkg::ANG_W-1:0]  fold_ang;
   logic                              fold_neg;
   logic signed [mlo_pkg::VEC_W-1:0]  shx, shy;
   logic signed [mlo_pkg::Z_W-1:0]    atan_z;

   always_comb begin
      // bring the angle into the right half plane, negate the result later
      priority if (angle > mlo_pkg::QUARTER_ANG) begin
         fold_ang = angle - mlo_pkg::YAW_HALF;
         fold_neg = 1'b1;
      end else if (angle < -mlo_pkg::QUARTER_ANG) begin
         fold_ang = angle + mlo_pkg::YAW_HALF;
         fold_neg = 1'b1;
      end else begin
         fold_ang = angle;
         fold_neg = 1'b0;
      end

      shx    = x_ff >>> cnt_ff;
      shy    = y_ff >>> cnt_ff;
      atan_z = mlo_pkg::atan_val(cnt_ff);

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;

      if (start) begin
         x_in    = mlo_pkg::CORDIC_X0;
         y_in    = '0;
         z_in    = {fold_ang, 8'h00};
         neg_in  = fold_neg;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - shy;
            y_in = y_ff + shx;
            z_in = z_ff - atan_z;
         end else begin
            x_in = x_ff + shy;
            y_in = y_ff - shx;
            z_in = z_ff + atan_z;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mlo_pkg::STEP_W'(mlo_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign res.done  = done_ff;
   assign res.cos_q = neg_ff ? -x_ff : x_ff;
   assign res.sin_q = neg_ff ? -y_ff : y_ff;

endmodule
`default_nettype wire

// File: rtl/mouse_look_orientation_core.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// req_      in         req_tvalid/tready    tdata: cursor_x, cursor_y
// rsp_      out        rsp_tvalid/tready    tdata: dir_x, dir_y, dir_z, yaw_angle, pitch_angle
// csr_      in         csr_we               csr_index, csr_wdata
//
// One item at a time, through two 16-step CORDIC runs on the single rotation unit, a
// nine-step modulo reduction of yaw and one 33x33 multiplier shared by all four products.
// A finished item waits in the output register; a later item may still be taken and then
// holds in the last step until that register is free. Reset is synchronous: angles,
// previous position and registers return to their defaults, first-sample flag set.
module mouse_look_orientation_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // cursor_x [15:0], cursor_y [31:16]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [87:0] rsp_tdata,   // dir_x, dir_y, dir_z, yaw_angle, pitch_angle, pad
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int ACC_W = 27;
   localparam int MUL_W = 33;
   localparam int PRD_W = 2 * MUL_W;

   localparam logic signed [ACC_W-1:0] YAW_FULL_A = 27'sd92160;
   localparam logic signed [ACC_W-1:0] YAW_HALF_A = 27'sd46080;
   localparam logic [14:0]             PITCH_MAX  = 15'd23040;
   localparam logic [3:0]              WRAP_TOP   = 4'd8;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MULX    = 4'd1;
   localparam logic [3:0] ST_MULY    = 4'd2;
   localparam logic [3:0] ST_PITCH   = 4'd3;
   localparam logic [3:0] ST_WRAP    = 4'd4;
   localparam logic [3:0] ST_WRAPFIX = 4'd5;
   localparam logic [3:0] ST_CYAW    = 4'd6;
   localparam logic [3:0] ST_WYAW    = 4'd7;
   localparam logic [3:0] ST_CPITCH  = 4'd8;
   localparam logic [3:0] ST_WPITCH  = 4'd9;
   localparam logic [3:0] ST_PRODX   = 4'd10;
   localparam logic [3:0] ST_PRODZ   = 4'd11;
   localparam logic [3:0] ST_FINZ    = 4'd12;
   localparam logic [3:0] ST_OUT     = 4'd13;

   logic [3:0]                        state_ff, state_in;
   logic [15:0]                       sens_ff, sens_in;
   logic [14:0]                       plim_ff, plim_in;
   logic                              first_ff, first_in;
   logic signed [15:0]                prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [16:0]                dx_ff, dx_in, dy_ff, dy_in;
   logic signed [16:0]                yaw_ff, yaw_in;
   logic signed [15:0]                pitch_ff, pitch_in;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;
   logic [3:0]                        wcnt_ff, wcnt_in;
   logic signed [PRD_W-1:0]           prod_ff, prod_in;
   logic signed [mlo_pkg::VEC_W-1:0]  cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in;
   logic signed [15:0]                dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic signed [15:0]                dir_z_ff, dir_z_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [87:0]                       rsp_data_ff, rsp_data_in;

   logic signed [15:0]                cur_x, cur_y;
   logic signed [MUL_W-1:0]           mul_a, mul_b;
   logic signed [PRD_W-1:0]           mul_p;
   logic signed [33:0]                rnd_sum;
   logic signed [25:0]                scaled;
   logic [14:0]                       lim;
   logic signed [ACC_W-1:0]           lim_s, pitch_sum, wrap_mod, wrap_fix, yaw_full;
   logic signed [32:0]                sin_sum;
   logic signed [16:0]                sin_q;
   logic                              cordic_start;
   logic signed [mlo_pkg::ANG_W-1:0]  cordic_ang;
   mlo_pkg::cordic_res_type           cres;

   function automatic logic signed [15:0] sat_dir(input logic signed [19:0] v);
      logic signed [15:0] r;
      priority if (v > 20'sd16384)
         r = 16'sd16384;
      else if (v < -20'sd16384)
         r = -16'sd16384;
      else
         r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [15:0] round46(input logic signed [PRD_W-1:0] p);
      logic signed [PRD_W-1:0] s;
      s = p + (PRD_W'(1) <<< 45);
      return sat_dir(s[65:46]);
   endfunction

   mlo_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (cordic_ang),
      .res   (cres)
   );

   assign cur_x        = req_tdata[15:0];
   assign cur_y        = req_tdata[31:16];
   assign cordic_start = (state_ff == ST_CYAW) || (state_ff == ST_CPITCH);
   assign cordic_ang   = (state_ff == ST_CPITCH) ? {pitch_ff[15], pitch_ff} : yaw_ff;

   // shared multiplier operand selection
   always_comb begin
      unique case (state_ff)
         ST_MULY: begin
            mul_a = {{(MUL_W-17){dy_ff[16]}}, dy_ff};
            mul_b = {{(MUL_W-16){1'b0}}, sens_ff};
         end
         ST_PRODX: begin
            mul_a = {cy_ff[31], cy_ff};
            mul_b = {cp_ff[31], cp_ff};
         end
         ST_PRODZ: begin
            mul_a = {sy_ff[31], sy_ff};
            mul_b = {cp_ff[31], cp_ff};
         end
         default: begin
            mul_a = {{(MUL_W-17){dx_ff[16]}}, dx_ff};
            mul_b = {{(MUL_W-16){1'b0}}, sens_ff};
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      rnd_sum   = prod_ff[33:0] + 34'sd128;
      scaled    = rnd_sum[33:8];
      lim       = (plim_ff > PITCH_MAX) ? PITCH_MAX : plim_ff;
      lim_s     = {{(ACC_W-15){1'b0}}, lim};
      pitch_sum = {{(ACC_W-16){pitch_ff[15]}}, pitch_ff}
                + {{(ACC_W-26){scaled[25]}}, scaled};
      yaw_full  = YAW_FULL_A;
      wrap_mod  = yaw_full <<< wcnt_ff;
      wrap_fix  = (acc_ff < 0) ? acc_ff + YAW_FULL_A : acc_ff;
      sin_sum   = {cres.sin_q[31], cres.sin_q} + 33'sd32768;
      sin_q     = sin_sum[32:16];
   end

   always_comb begin
      state_in     = state_ff;
      sens_in      = sens_ff;
      plim_in      = plim_ff;
      first_in     = first_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      acc_in       = acc_ff;
      wcnt_in      = wcnt_ff;
      prod_in      = prod_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      cp_in        = cp_ff;
      dir_x_in     = dir_x_ff;
      dir_y_in     = dir_y_ff;
      dir_z_in     = dir_z_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            mlo_pkg::REG_SENSITIVITY: sens_in = csr_wdata;
            mlo_pkg::REG_PITCH_LIMIT: plim_in = csr_wdata[14:0];
         endcase
      end

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // the first item records the position and moves no angle
               if (first_ff) begin
                  dx_in = '0;
                  dy_in = '0;
               end else begin
                  dx_in = {cur_x[15], cur_x} - {prev_x_ff[15], prev_x_ff};
                  dy_in = {prev_y_ff[15], prev_y_ff} - {cur_y[15], cur_y};
               end
               first_in  = 1'b0;
               prev_x_in = cur_x;
               prev_y_in = cur_y;
               state_in  = ST_MULX;
            end
         end
         ST_MULX: begin
            prod_in  = mul_p;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            prod_in  = mul_p;
            acc_in   = {{(ACC_W-17){yaw_ff[16]}}, yaw_ff}
                     + {{(ACC_W-26){scaled[25]}}, scaled} + YAW_HALF_A;
            state_in = ST_PITCH;
         end
         ST_PITCH: begin
            priority if (pitch_sum > lim_s)
               pitch_in = lim_s[15:0];
            else if (pitch_sum < -lim_s)
               pitch_in = pitch_sum[15:0] - pitch_sum[15:0] - lim_s[15:0];
            else
               pitch_in = pitch_sum[15:0];
            wcnt_in  = WRAP_TOP;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            // shrink the magnitude below the modulus times 2^wcnt each step
            priority if (acc_ff >= wrap_mod)
               acc_in = acc_ff - wrap_mod;
            else if (acc_ff < 0)
               acc_in = acc_ff + wrap_mod;
            else
               acc_in = acc_ff;
            if (wcnt_ff == '0)
               state_in = ST_WRAPFIX;
            else
               wcnt_in = wcnt_ff - 1'b1;
         end
         ST_WRAPFIX: begin
            yaw_in   = 17'(wrap_fix - YAW_HALF_A);
            state_in = ST_CYAW;
         end
         ST_CYAW: begin
            state_in = ST_WYAW;
         end
         ST_WYAW: begin
            if (cres.done) begin
               cy_in    = cres.cos_q;
               sy_in    = cres.sin_q;
               state_in = ST_CPITCH;
            end
         end
         ST_CPITCH: begin
            state_in = ST_WPITCH;
         end
         ST_WPITCH: begin
            if (cres.done) begin
               cp_in    = cres.cos_q;
               dir_y_in = sat_dir({{3{sin_q[16]}}, sin_q});
               state_in = ST_PRODX;
            end
         end
         ST_PRODX: begin
            prod_in  = mul_p;
            state_in = ST_PRODZ;
         end
         ST_PRODZ: begin
            dir_x_in = round46(prod_ff);
            prod_in  = mul_p;
            state_in = ST_FINZ;
         end
         ST_FINZ: begin
            dir_z_in = round46(prod_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, pitch_ff, yaw_ff, dir_z_ff, dir_y_ff, dir_x_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sens_ff      <= 16'd6554;
         plim_ff      <= 15'd22784;
         first_ff     <= 1'b1;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         wcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sens_ff      <= sens_in;
         plim_ff      <= plim_in;
         first_ff     <= first_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         wcnt_ff      <= wcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      cy_ff       <= cy_in;
      sy_ff       <= sy_in;
      cp_ff       <= cp_in;
      dir_x_ff    <= dir_x_in;
      dir_y_ff    <= dir_y_in;
      dir_z_ff    <= dir_z_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: verif/mouse_look_orientation_core_test.sv
`default_nettype none
module mouse_look_orientation_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint YAW_TURN   = 92160;
   localparam longint PITCH_TOP  = 23040;
   localparam longint Q14_ONE    = 16384;
   localparam int     SETTLE_CYC = 60;

   localparam longint ARCTAN_STEP [0:15] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [16:0] yaw_angle;
      logic signed [15:0] pitch_angle;
   } view_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // cursor_x [15:0], cursor_y [31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // dir_x, dir_y, dir_z, yaw_angle (17), pitch_angle, pad
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;

   // view state and register copies
   longint sensitivity_reg;
   longint pitch_limit_reg;
   longint last_x;
   longint last_y;
   longint yaw_acc;
   longint pitch_acc;
   bit     awaiting_first;

   view_result_type expected_views [$];

   int error_count;
   int items_sent;
   int views_checked;
   int reg_writes;
   int tx_idle_pct;
   int rx_idle_pct;
   int rx_hold;

   mouse_look_orientation_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("simulation failed");
      $finish;
   end

   function automatic longint scaled_step(input longint delta);
      return (delta * sensitivity_reg + 128) >>> 8;
   endfunction

   function automatic longint saturate_q14(input longint v);
      if (v > Q14_ONE) return Q14_ONE;
      if (v < -Q14_ONE) return -Q14_ONE;
      return v;
   endfunction

   // cosine and sine of an angle in 1/256 degree, both in Q1.30
   function automatic void rotate_unit(input longint ang, output longint c, output longint s);
      longint x, y, z, nx;
      bit     flip;
      int     i;
      x = longint'(mlo_pkg::CORDIC_X0);
      y = 0;
      flip = 1'b0;
      if (ang > longint'(mlo_pkg::QUARTER_ANG)) begin
         ang = ang - longint'(mlo_pkg::YAW_HALF);
         flip = 1'b1;
      end else if (ang < -longint'(mlo_pkg::QUARTER_ANG)) begin
         ang = ang + longint'(mlo_pkg::YAW_HALF);
         flip = 1'b1;
      end
      z = ang * 256;
      for (i = 0; i < mlo_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ARCTAN_STEP[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ARCTAN_STEP[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic void predict_view(input logic signed [15:0] cx, input logic signed [15:0] cy);
      longint x, y, dx, dy, ny, np, lim, cyaw, syaw, cpit, spit;
      view_result_type r;
      x = cx;
      y = cy;
      if (awaiting_first) begin
         last_x = x;
         last_y = y;
         awaiting_first = 1'b0;
      end
      dx = x - last_x;
      dy = last_y - y;
      last_x = x;
      last_y = y;
      ny = (yaw_acc + scaled_step(dx) + longint'(mlo_pkg::YAW_HALF)) % YAW_TURN;
      if (ny < 0) ny = ny + YAW_TURN;
      yaw_acc = ny - longint'(mlo_pkg::YAW_HALF);
      lim = (pitch_limit_reg > PITCH_TOP) ? PITCH_TOP : pitch_limit_reg;
      np = pitch_acc + scaled_step(dy);
      if (np > lim) np = lim;
      if (np < -lim) np = -lim;
      pitch_acc = np;
      rotate_unit(yaw_acc, cyaw, syaw);
      rotate_unit(pitch_acc, cpit, spit);
      r.dir_x       = 16'(saturate_q14((cyaw * cpit + (longint'(1) << 45)) >>> 46));
      r.dir_y       = 16'(saturate_q14((spit + (longint'(1) << 15)) >>> 16));
      r.dir_z       = 16'(saturate_q14((syaw * cpit + (longint'(1) << 45)) >>> 46));
      r.yaw_angle   = 17'(yaw_acc);
      r.pitch_angle = 16'(pitch_acc);
      expected_views.push_back(r);
   endfunction

   // receiver: random stalls, or a long counted hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            rx_hold = rx_hold - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      view_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.dir_x       = rsp_tdata[15:0];
         got.dir_y       = rsp_tdata[31:16];
         got.dir_z       = rsp_tdata[47:32];
         got.yaw_angle   = rsp_tdata[64:48];
         got.pitch_angle = rsp_tdata[80:65];
         if (expected_views.size() == 0) begin
            $error("view result with nothing expected");
            error_count++;
         end else begin
            want = expected_views.pop_front();
            views_checked++;
            if (got.dir_x !== want.dir_x) begin
               $error("dir_x expected %0d got %0d", want.dir_x, got.dir_x);
               error_count++;
            end
            if (got.dir_y !== want.dir_y) begin
               $error("dir_y expected %0d got %0d", want.dir_y, got.dir_y);
               error_count++;
            end
            if (got.dir_z !== want.dir_z) begin
               $error("dir_z expected %0d got %0d", want.dir_z, got.dir_z);
               error_count++;
            end
            if (got.yaw_angle !== want.yaw_angle) begin
               $error("yaw_angle expected %0d got %0d", want.yaw_angle, got.yaw_angle);
               error_count++;
            end
            if (got.pitch_angle !== want.pitch_angle) begin
               $error("pitch_angle expected %0d got %0d", want.pitch_angle, got.pitch_angle);
               error_count++;
            end
         end
      end
   end

   task automatic send_cursor(input logic signed [15:0] x, input logic signed [15:0] y);
      int gap;
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_view(x, y);
      items_sent++;
   endtask

   // drop valid and hold until every view is back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == mlo_pkg::REG_SENSITIVITY) sensitivity_reg = value;
      else pitch_limit_reg = value[14:0];
      reg_writes++;
   endtask

   // with a gain of 512 every pixel turns two units; pick cursor moves that land near a target
   task automatic aim_view(input longint yaw_t, input longint pitch_t);
      longint dx, dy, nx, ny;
      dx = (yaw_t - yaw_acc) % YAW_TURN;
      if (dx >= longint'(mlo_pkg::YAW_HALF)) dx = dx - YAW_TURN;
      if (dx < -longint'(mlo_pkg::YAW_HALF)) dx = dx + YAW_TURN;
      dx = dx / 2;
      nx = last_x + dx;
      if (nx > 32767) nx = nx - 46080;
      if (nx < -32768) nx = nx + 46080;
      dy = (pitch_t - pitch_acc) / 2;
      ny = last_y - dy;
      if (ny > 32767) ny = 32767;
      if (ny < -32768) ny = -32768;
      send_cursor(16'(nx), 16'(ny));
   endtask

   task automatic test_first_and_extremes();
      send_cursor(16'sd100, -16'sd50);
      send_cursor(16'sd100, -16'sd50);
      send_cursor(16'sd110, -16'sd40);
      send_cursor(16'sd32767, 16'sd32767);
      send_cursor(-16'sd32768, -16'sd32768);
      send_cursor(-16'sd32768, -16'sd32768);
      send_cursor(16'sd0, 16'sd0);
   endtask

   task automatic test_angle_edges();
      wait_idle();
      write_reg(mlo_pkg::REG_SENSITIVITY, 16'd512);
      write_reg(mlo_pkg::REG_PITCH_LIMIT, 16'h7FFF);
      aim_view(0, 0);
      aim_view(23040, 0);
      aim_view(23042, 10000);
      aim_view(-23042, -10000);
      aim_view(46078, 23040);
      aim_view(-46080, -23040);
      aim_view(0, 23040);
      // lower the limit under a raised pitch, then move nowhere
      wait_idle();
      write_reg(mlo_pkg::REG_PITCH_LIMIT, 16'd2560);
      send_cursor(16'(last_x), 16'(last_y));
      wait_idle();
      write_reg(mlo_pkg::REG_PITCH_LIMIT, 16'd0);
      send_cursor(16'(last_x), 16'(last_y - 5));
      wait_idle();
      write_reg(mlo_pkg::REG_SENSITIVITY, 16'd0);
      write_reg(mlo_pkg::REG_PITCH_LIMIT, 16'd23040);
      send_cursor(16'sd12345, -16'sd12345);
      wait_idle();
      write_reg(mlo_pkg::REG_SENSITIVITY, 16'hFFFF);
      send_cursor(-16'sd32768, 16'sd32767);
      send_cursor(16'sd32767, -16'sd32768);
      send_cursor(16'sd32767, -16'sd32767);
   endtask

   task automatic send_random_cursor();
      int nx, ny;
      if ($urandom_range(99) < 80) begin
         nx = int'(last_x) + $urandom_range(600) - 300;
         ny = int'(last_y) + $urandom_range(600) - 300;
         if (nx > 32767) nx = 32767;
         if (nx < -32768) nx = -32768;
         if (ny > 32767) ny = 32767;
         if (ny < -32768) ny = -32768;
         send_cursor(16'(nx), 16'(ny));
      end else begin
         send_cursor(16'($urandom()), 16'($urandom()));
      end
   endtask

   task automatic test_random_motion();
      int phase, chunk, n;
      logic [15:0] gain, limit;
      for (phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 76 : 0;
         rx_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 35 : 0;
         for (chunk = 0; chunk < 4; chunk++) begin
            wait_idle();
            case ($urandom_range(3))
               0: gain = 16'($urandom_range(65535));
               1: gain = 16'($urandom_range(1, 2048));
               2: gain = 16'hFFFF;
               default: gain = 16'd6554;
            endcase
            case ($urandom_range(3))
               0: limit = 16'($urandom_range(23040));
               1: limit = 16'd23040;
               2: limit = 16'($urandom_range(32767, 23041));
               default: limit = 16'($urandom_range(512));
            endcase
            write_reg(mlo_pkg::REG_SENSITIVITY, gain);
            write_reg(mlo_pkg::REG_PITCH_LIMIT, limit);
            for (n = 0; n < 115; n++) send_random_cursor();
         end
      end
   endtask

   task automatic test_backpressure();
      int n;
      tx_idle_pct = 0;
      rx_idle_pct = 20;
      wait_idle();
      write_reg(mlo_pkg::REG_SENSITIVITY, 16'd6554);
      write_reg(mlo_pkg::REG_PITCH_LIMIT, 16'd22784);
      rx_hold = 500;
      for (n = 0; n < 12; n++) send_random_cursor();
      // pause until every view is back, then resume
      wait_idle();
      for (n = 0; n < 10; n++) send_random_cursor();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      error_count   = 0;
      items_sent    = 0;
      views_checked = 0;
      reg_writes    = 0;
      tx_idle_pct   = 0;
      rx_idle_pct   = 0;
      rx_hold       = 0;
      sensitivity_reg = 6554;
      pitch_limit_reg = 22784;
      last_x    = 0;
      last_y    = 0;
      yaw_acc   = 0;
      pitch_acc = 0;
      awaiting_first = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_and_extremes();
      test_angle_edges();
      test_random_motion();
      test_backpressure();
      wait_idle();

      $display("Sent %0d cursor items over %0d register writes; %0d views checked, %0d errors.",
               items_sent, reg_writes, views_checked, error_count);
      $display("Gains and pitch limits ran from zero to full scale, with yaw wrap and clamping.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
